/* rtl/power_controller_command_slave_top_defines.svh */
// ----------------------------------------------------------------------------
// power_controller_command_slave_top_defines
// Assertion macros shared by the power controller command slave RTL.
// ----------------------------------------------------------------------------
`ifndef POWER_CONTROLLER_COMMAND_SLAVE_TOP_DEFINES_SVH
`define POWER_CONTROLLER_COMMAND_SLAVE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, inactive while reset is high
`define PCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check, active during reset too
`define PCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCS_ASSERT(lbl, clk, rst, prop, msg)
`define PCS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/pcs_pkg.sv */
// ----------------------------------------------------------------------------
// pcs_pkg
// Opcodes, mode codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pcs_pkg;

   localparam logic [7:0] OP_JUMP        = 8'h06;
   localparam logic [7:0] OP_RESET       = 8'h07;
   localparam logic [7:0] OP_SET_VOLT    = 8'h10;
   localparam logic [7:0] OP_SET_ID      = 8'h12;
   localparam logic [7:0] OP_GET_ID      = 8'h13;
   localparam logic [7:0] OP_ENABLE      = 8'h15;
   localparam logic [7:0] OP_HEARTBEAT   = 8'h16;
   localparam logic [7:0] OP_GET_VERSION = 8'h17;
   localparam logic [7:0] OP_GET_VOLT    = 8'h18;

   localparam logic [1:0] MODE_RESET = 2'd0;
   localparam logic [1:0] MODE_APP   = 2'd2;

   localparam logic [4:0] POS_MAX       = 5'd31;
   localparam logic [7:0] VERSION_RESET = 8'd3;

   typedef struct packed {
      logic take_byte;
      logic load_reply;
      logic next_byte;
   } pcs_cmd_type;

   typedef struct packed {
      logic frame_last;
      logic reply_last;
   } pcs_stat_type;

endpackage

/* rtl/pcs_datapath.sv */
// ----------------------------------------------------------------------------
// pcs_datapath
// Frame decode, device state, board name store and reply register.
// ----------------------------------------------------------------------------
`include "power_controller_command_slave_top_defines.svh"

module pcs_datapath #(
   parameter int NAME_BYTES = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  pcs_pkg::pcs_cmd_type  cmd,
   output pcs_pkg::pcs_stat_type stat,
   input  logic [7:0]         cmd_byte,
   input  logic               frame_last,
   input  logic [31:0]        now_seconds,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   output logic [7:0]         resp_byte,
   output logic               has_data,
   output logic               resp_last,
   output logic               status,
   output logic               power_enable,
   output logic [1:0]         mode,
   output logic [31:0]        heartbeat_stamp
);
   import pcs_pkg::*;

   localparam int IDX_W = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;

   logic [7:0]       name_ff [NAME_BYTES];
   logic [7:0]       name_in [NAME_BYTES];
   logic [7:0]       volt_ff, volt_in;
   logic             enable_ff, enable_in;
   logic [1:0]       mode_ff, mode_in;
   logic [31:0]      hb_ff, hb_in;
   logic [4:0]       pos_ff, pos_in;
   logic [7:0]       opcode_ff, opcode_in;
   logic [7:0]       arg_ff, arg_in;
   logic             seen_ff, seen_in;
   logic [7:0]       version_ff, version_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_data_ff, rsp_data_in;
   logic             rsp_err_ff, rsp_err_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [7:0]       eff_op;
   logic [7:0]       eff_arg;
   logic             eff_seen;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] idx_nx;

   always_comb begin
      eff_op   = (pos_ff == 5'd0) ? cmd_byte : opcode_ff;
      eff_arg  = (pos_ff == 5'd1) ? cmd_byte : ((pos_ff == 5'd0) ? 8'd0 : arg_ff);
      eff_seen = (pos_ff == 5'd0) ? 1'b0 : ((pos_ff == 5'd1) ? 1'b1 : seen_ff);
      wr_idx   = IDX_W'(pos_ff - 5'd1);
      idx_nx   = idx_ff + IDX_W'(1);
   end

   always_comb begin
      name_in     = name_ff;
      volt_in     = volt_ff;
      enable_in   = enable_ff;
      mode_in     = mode_ff;
      hb_in       = hb_ff;
      pos_in      = pos_ff;
      opcode_in   = opcode_ff;
      arg_in      = arg_ff;
      seen_in     = seen_ff;
      version_in  = csr_wr_en ? csr_wr_data : version_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_data_in = rsp_data_ff;
      rsp_err_in  = rsp_err_ff;
      rsp_last_in = rsp_last_ff;
      idx_in      = idx_ff;

      if (cmd.take_byte) begin
         if (pos_ff == 5'd0) begin
            opcode_in = cmd_byte;
            seen_in   = 1'b0;
            arg_in    = 8'd0;
         end else begin
            if (pos_ff == 5'd1) begin
               arg_in  = cmd_byte;
               seen_in = 1'b1;
            end
            if (opcode_ff == OP_SET_ID && pos_ff <= 5'(NAME_BYTES)) begin
               name_in[wr_idx] = cmd_byte;
            end
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 5'd1;
         end
      end

      if (cmd.load_reply) begin
         pos_in      = 5'd0;
         seen_in     = 1'b0;
         rsp_byte_in = 8'd0;
         rsp_data_in = 1'b0;
         rsp_err_in  = 1'b0;
         rsp_last_in = 1'b1;
         idx_in      = '0;
         unique case (eff_op)
            OP_JUMP: begin
               mode_in = MODE_APP;
            end
            OP_RESET: begin
               enable_in = 1'b0;
               mode_in   = MODE_RESET;
            end
            OP_ENABLE: begin
               if (eff_seen) enable_in = (eff_arg != 8'd0);
            end
            OP_SET_VOLT: begin
               if (eff_seen) volt_in = eff_arg;
            end
            OP_SET_ID: begin
            end
            OP_HEARTBEAT: begin
               hb_in = now_seconds;
            end
            OP_GET_ID: begin
               rsp_byte_in = name_ff[0];
               rsp_data_in = 1'b1;
               rsp_last_in = (NAME_BYTES == 1);
            end
            OP_GET_VOLT: begin
               rsp_byte_in = volt_ff;
               rsp_data_in = 1'b1;
            end
            OP_GET_VERSION: begin
               rsp_byte_in = version_ff;
               rsp_data_in = 1'b1;
            end
            default: begin
               rsp_err_in = 1'b1;
            end
         endcase
      end

      if (cmd.next_byte) begin
         idx_in      = idx_nx;
         rsp_byte_in = name_ff[idx_nx];
         rsp_last_in = (idx_nx == IDX_W'(NAME_BYTES - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NAME_BYTES; i++) name_ff[i] <= 8'd0;
         volt_ff     <= 8'd0;
         enable_ff   <= 1'b0;
         mode_ff     <= MODE_RESET;
         hb_ff       <= 32'd0;
         pos_ff      <= 5'd0;
         opcode_ff   <= 8'd0;
         arg_ff      <= 8'd0;
         seen_ff     <= 1'b0;
         version_ff  <= VERSION_RESET;
         rsp_byte_ff <= 8'd0;
         rsp_data_ff <= 1'b0;
         rsp_err_ff  <= 1'b0;
         rsp_last_ff <= 1'b1;
         idx_ff      <= '0;
      end else begin
         name_ff     <= name_in;
         volt_ff     <= volt_in;
         enable_ff   <= enable_in;
         mode_ff     <= mode_in;
         hb_ff       <= hb_in;
         pos_ff      <= pos_in;
         opcode_ff   <= opcode_in;
         arg_ff      <= arg_in;
         seen_ff     <= seen_in;
         version_ff  <= version_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_data_ff <= rsp_data_in;
         rsp_err_ff  <= rsp_err_in;
         rsp_last_ff <= rsp_last_in;
         idx_ff      <= idx_in;
      end
   end

   assign stat.frame_last  = frame_last;
   assign stat.reply_last  = rsp_last_ff;
   assign resp_byte        = rsp_byte_ff;
   assign has_data         = rsp_data_ff;
   assign resp_last        = rsp_last_ff;
   assign status           = rsp_err_ff;
   assign power_enable     = enable_ff;
   assign mode             = mode_ff;
   assign heartbeat_stamp  = hb_ff;

   `PCS_ASSERT(a_pos_cleared, clock, reset, cmd.load_reply |=> (pos_ff == 5'd0), "frame position not cleared at frame end")
   `PCS_ASSERT(a_pos_step, clock, reset, (cmd.take_byte && !cmd.load_reply && pos_ff != POS_MAX) |=> (pos_ff == $past(pos_ff) + 5'd1), "frame position did not advance")
   `PCS_ASSERT(a_stream_data, clock, reset, cmd.next_byte |=> (rsp_data_ff && !rsp_err_ff), "name stream lost its data flag")

endmodule

/* rtl/pcs_ctrl.sv */
// ----------------------------------------------------------------------------
// pcs_ctrl
// Sequencer: receives frame bytes, then holds the input while a reply drains.
// ----------------------------------------------------------------------------
`include "power_controller_command_slave_top_defines.svh"

module pcs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  pcs_pkg::pcs_stat_type stat,
   output pcs_pkg::pcs_cmd_type  cmd
);
   import pcs_pkg::*;

   typedef enum logic [1:0] {
      ST_RX = 2'b01,
      ST_TX = 2'b10
   } pcs_state_type;

   pcs_state_type state_ff, state_in;
   logic          rx_xfer;
   logic          tx_xfer;

   assign req_stall = (state_ff != ST_RX);
   assign rsp_valid = (state_ff == ST_TX);
   assign rx_xfer   = req_valid && (state_ff == ST_RX);
   assign tx_xfer   = (state_ff == ST_TX) && !rsp_stall;

   assign cmd.take_byte  = rx_xfer;
   assign cmd.load_reply = rx_xfer && stat.frame_last;
   assign cmd.next_byte  = tx_xfer && !stat.reply_last;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RX: begin
            if (rx_xfer && stat.frame_last) state_in = ST_TX;
         end
         ST_TX: begin
            if (tx_xfer && stat.reply_last) state_in = ST_RX;
         end
         default: begin
            state_in = ST_RX;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RX;
      end else begin
         state_ff <= state_in;
      end
   end

   `PCS_ASSERT(a_reply_follows, clock, reset, cmd.load_reply |=> rsp_valid, "no reply after frame end")
   `PCS_ASSERT(a_stream_holds, clock, reset, cmd.next_byte |=> (rsp_valid && req_stall), "reply stream dropped early")
   `PCS_ASSERT(a_reply_done, clock, reset, (tx_xfer && stat.reply_last) |=> !rsp_valid, "reply not closed on last transfer")
   `PCS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "reply pending after reset")

endmodule

/* rtl/power_controller_command_slave_top.sv */
// A reply is offered in the cycle after the transfer of the frame's last byte.
// One frame byte is taken per cycle until the last byte; the input then stalls
// until the reply drains, one result per unstalled cycle (1 result, or NAME_BYTES for get-id).
// Reset (synchronous, active high): board name, voltage, enable, mode and heartbeat
// clear to zero, the version register loads 3, and the block waits for an opcode.
// ----------------------------------------------------------------------------
// power_controller_command_slave_top
// Byte-framed command slave for board power control.
// ----------------------------------------------------------------------------
module power_controller_command_slave_top #(
   parameter int NAME_BYTES = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_cmd_byte,
   input  logic        req_frame_last,
   input  logic [31:0] req_now_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_resp_byte,
   output logic        rsp_has_data,
   output logic        rsp_resp_last,
   output logic        rsp_status,
   output logic        rsp_power_enable,
   output logic [1:0]  rsp_mode,
   output logic [31:0] rsp_heartbeat_stamp,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import pcs_pkg::*;

   pcs_cmd_type  cmd;
   pcs_stat_type stat;

   pcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcs_datapath #(
      .NAME_BYTES (NAME_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .cmd_byte        (req_cmd_byte),
      .frame_last      (req_frame_last),
      .now_seconds     (req_now_seconds),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .resp_byte       (rsp_resp_byte),
      .has_data        (rsp_has_data),
      .resp_last       (rsp_resp_last),
      .status          (rsp_status),
      .power_enable    (rsp_power_enable),
      .mode            (rsp_mode),
      .heartbeat_stamp (rsp_heartbeat_stamp)
   );

endmodule

/* tb/pcs_reply_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_reply_pkg
// Reply predictor and scoreboard for the power controller command slave.
// Tracks frame parsing and board state, and queues the replies due for each
// completed command frame.
// ----------------------------------------------------------------------------
package pcs_reply_pkg;

   import pcs_pkg::*;

   localparam int NAME_BYTES = 12;

   localparam logic ST_ACCEPTED    = 1'b0;
   localparam logic ST_BAD_OPCODE  = 1'b1;

   typedef struct packed {
      logic [7:0]  data;
      logic        has_data;
      logic        last;
      logic        status;
      logic        power_enable;
      logic [1:0]  mode;
      logic [31:0] stamp;
   } pcs_reply_type;

   class cmd_reply_book_type;
      logic [7:0]    version;
      logic [7:0]    id_bytes [NAME_BYTES];
      logic [7:0]    voltage;
      logic          enable_level;
      logic [1:0]    mode;
      logic [31:0]   heartbeat;
      int unsigned   frame_pos;
      logic [7:0]    opcode;
      logic [7:0]    arg_byte;
      logic          arg_seen;
      pcs_reply_type replies_due [$];
      int unsigned   mismatches;
      int unsigned   replies_seen;

      function new();
         version = VERSION_RESET;
         foreach (id_bytes[i]) id_bytes[i] = 8'h00;
         voltage      = 8'h00;
         enable_level = 1'b0;
         mode         = MODE_RESET;
         heartbeat    = 32'h0;
         frame_pos    = 0;
         opcode       = 8'h00;
         arg_byte     = 8'h00;
         arg_seen     = 1'b0;
         mismatches   = 0;
         replies_seen = 0;
      endfunction

      function void set_version(logic [7:0] value);
         version = value;
      endfunction

      function void queue_reply(logic [7:0] data, logic has, logic last, logic st);
         pcs_reply_type r;
         r.data         = data;
         r.has_data     = has;
         r.last         = last;
         r.status       = st;
         r.power_enable = enable_level;
         r.mode         = mode;
         r.stamp        = heartbeat;
         replies_due.push_back(r);
      endfunction

      function void take_cmd_byte(logic [7:0] b, logic last, logic [31:0] now);
         if (frame_pos == 0) begin
            opcode   = b;
            arg_seen = 1'b0;
            arg_byte = 8'h00;
         end else begin
            if (frame_pos == 1) begin
               arg_byte = b;
               arg_seen = 1'b1;
            end
            if (opcode == OP_SET_ID && frame_pos <= NAME_BYTES)
               id_bytes[frame_pos - 1] = b;
         end
         if (frame_pos < POS_MAX) frame_pos++;
         if (!last) return;

         case (opcode)
            OP_JUMP: begin
               mode = MODE_APP;
               queue_reply(8'h00, 1'b0, 1'b1, ST_ACCEPTED);
            end
            OP_RESET: begin
               enable_level = 1'b0;
               mode         = MODE_RESET;
               queue_reply(8'h00, 1'b0, 1'b1, ST_ACCEPTED);
            end
            OP_ENABLE: begin
               if (arg_seen) enable_level = (arg_byte != 8'h00);
               queue_reply(8'h00, 1'b0, 1'b1, ST_ACCEPTED);
            end
            OP_SET_VOLT: begin
               if (arg_seen) voltage = arg_byte;
               queue_reply(8'h00, 1'b0, 1'b1, ST_ACCEPTED);
            end
            OP_SET_ID: begin
               queue_reply(8'h00, 1'b0, 1'b1, ST_ACCEPTED);
            end
            OP_HEARTBEAT: begin
               heartbeat = now;
               queue_reply(8'h00, 1'b0, 1'b1, ST_ACCEPTED);
            end
            OP_GET_ID: begin
               for (int i = 0; i < NAME_BYTES; i++)
                  queue_reply(id_bytes[i], 1'b1, i == NAME_BYTES - 1, ST_ACCEPTED);
            end
            OP_GET_VOLT: begin
               queue_reply(voltage, 1'b1, 1'b1, ST_ACCEPTED);
            end
            OP_GET_VERSION: begin
               queue_reply(version, 1'b1, 1'b1, ST_ACCEPTED);
            end
            default: begin
               queue_reply(8'h00, 1'b0, 1'b1, ST_BAD_OPCODE);
            end
         endcase
         frame_pos = 0;
         arg_seen  = 1'b0;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      task match_reply(pcs_reply_type got);
         pcs_reply_type want;
         replies_seen++;
         if (replies_due.size() == 0) begin
            report_mismatch($sformatf("reply %0d arrived with none due, data %02h",
                                      replies_seen, got.data));
            return;
         end
         want = replies_due.pop_front();
         if (got.data !== want.data)
            report_mismatch($sformatf("reply %0d data %02h, want %02h",
                                      replies_seen, got.data, want.data));
         if (got.has_data !== want.has_data)
            report_mismatch($sformatf("reply %0d has_data %b, want %b",
                                      replies_seen, got.has_data, want.has_data));
         if (got.last !== want.last)
            report_mismatch($sformatf("reply %0d last %b, want %b",
                                      replies_seen, got.last, want.last));
         if (got.status !== want.status)
            report_mismatch($sformatf("reply %0d status %b, want %b",
                                      replies_seen, got.status, want.status));
         if (got.power_enable !== want.power_enable)
            report_mismatch($sformatf("reply %0d power_enable %b, want %b",
                                      replies_seen, got.power_enable, want.power_enable));
         if (got.mode !== want.mode)
            report_mismatch($sformatf("reply %0d mode %0d, want %0d",
                                      replies_seen, got.mode, want.mode));
         if (got.stamp !== want.stamp)
            report_mismatch($sformatf("reply %0d stamp %08h, want %08h",
                                      replies_seen, got.stamp, want.stamp));
      endtask
   endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the power controller command slave.
// Directed frames cover every opcode and argument corner, then random frames
// run under varied sender gaps and receiver stalls; each reply transfer is
// compared against the predicted reply stream.
// ----------------------------------------------------------------------------
module tb_top;

   import pcs_pkg::*;
   import pcs_reply_pkg::*;

   localparam int RUN_LIMIT_NS = 2_000_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_cmd_byte;
   logic        req_frame_last;
   logic [31:0] req_now_seconds;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_resp_byte;
   logic        rsp_has_data;
   logic        rsp_resp_last;
   logic        rsp_status;
   logic        rsp_power_enable;
   logic [1:0]  rsp_mode;
   logic [31:0] rsp_heartbeat_stamp;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned bytes_sent     = 0;
   logic [7:0]  frame_bytes [$];

   cmd_reply_book_type book = new();

   power_controller_command_slave_top #(
      .NAME_BYTES (NAME_BYTES)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd_byte        (req_cmd_byte),
      .req_frame_last      (req_frame_last),
      .req_now_seconds     (req_now_seconds),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_resp_byte       (rsp_resp_byte),
      .rsp_has_data        (rsp_has_data),
      .rsp_resp_last       (rsp_resp_last),
      .rsp_status          (rsp_status),
      .rsp_power_enable    (rsp_power_enable),
      .rsp_mode            (rsp_mode),
      .rsp_heartbeat_stamp (rsp_heartbeat_stamp),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("run limit reached");
      $display("TB_ERROR");
      $finish;
   end

   // receiver side: stall pattern changes on the falling edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : watch_replies
      pcs_reply_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.data         = rsp_resp_byte;
         got.has_data     = rsp_has_data;
         got.last         = rsp_resp_last;
         got.status       = rsp_status;
         got.power_enable = rsp_power_enable;
         got.mode         = rsp_mode;
         got.stamp        = rsp_heartbeat_stamp;
         book.match_reply(got);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic l, input logic [31:0] now);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_cmd_byte    = b;
      req_frame_last  = l;
      req_now_seconds = now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.take_cmd_byte(b, l, now);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [31:0] last_now);
      int n;
      n = frame_bytes.size();
      for (int k = 0; k < n; k++)
         send_byte(frame_bytes[k], k == n - 1, (k == n - 1) ? last_now : $urandom);
   endtask

   task automatic start_frame(input logic [7:0] op);
      frame_bytes.delete();
      frame_bytes.push_back(op);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (book.replies_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_version(input logic [7:0] value);
      wait_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      book.set_version(value);
   endtask

   function automatic logic [7:0] pick_opcode();
      case ($urandom_range(8))
         0:       return OP_JUMP;
         1:       return OP_RESET;
         2:       return OP_SET_VOLT;
         3:       return OP_SET_ID;
         4:       return OP_GET_ID;
         5:       return OP_ENABLE;
         6:       return OP_HEARTBEAT;
         7:       return OP_GET_VERSION;
         default: return OP_GET_VOLT;
      endcase
   endfunction

   task automatic random_frame();
      logic [7:0] op;
      int unsigned n_args;
      if ($urandom_range(99) < 85) op = pick_opcode();
      else op = 8'($urandom_range(255));
      if (op == OP_SET_ID) n_args = $urandom_range(16);
      else n_args = $urandom_range(2);
      start_frame(op);
      repeat (n_args) frame_bytes.push_back(8'($urandom_range(255)));
      send_frame($urandom);
   endtask

   task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                            input int unsigned n_bytes, input bit long_frame);
      int unsigned target;
      send_idle_pct  = s_pct;
      recv_stall_pct = r_pct;
      target = bytes_sent + n_bytes;
      if (long_frame) begin
         // runs the frame position into saturation, then reads the name back
         start_frame(OP_SET_ID);
         repeat (35) frame_bytes.push_back(8'($urandom_range(255)));
         send_frame($urandom);
         start_frame(OP_GET_ID);
         send_frame($urandom);
      end
      while (bytes_sent < target) begin
         random_frame();
         if ($urandom_range(99) < 8) wait_drained();
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd_byte    = 8'h00;
      req_frame_last  = 1'b0;
      req_now_seconds = 32'h0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed frames
      start_frame(OP_GET_VERSION);  send_frame($urandom);
      start_frame(OP_GET_ID);       send_frame($urandom);
      start_frame(OP_GET_VOLT);     send_frame($urandom);
      start_frame(OP_SET_VOLT);     frame_bytes.push_back(8'hFF); send_frame($urandom);
      start_frame(OP_SET_VOLT);     send_frame($urandom);
      start_frame(OP_GET_VOLT);     send_frame($urandom);
      start_frame(OP_ENABLE);       frame_bytes.push_back(8'h80); send_frame($urandom);
      start_frame(OP_ENABLE);       send_frame($urandom);
      start_frame(OP_JUMP);         send_frame($urandom);
      start_frame(OP_HEARTBEAT);    send_frame(32'hFFFF_FFFF);
      start_frame(OP_RESET);        send_frame($urandom);
      start_frame(OP_SET_ID);
      frame_bytes.push_back(8'hA5);
      frame_bytes.push_back(8'h5A);
      frame_bytes.push_back(8'hC3);
      send_frame($urandom);
      start_frame(OP_SET_ID);       send_frame($urandom);
      start_frame(OP_GET_ID);       send_frame($urandom);
      start_frame(OP_ENABLE);
      frame_bytes.push_back(8'h01);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'h77);
      send_frame($urandom);
      start_frame(8'h00);           send_frame($urandom);
      start_frame(8'hFF);           frame_bytes.push_back(8'h12); send_frame($urandom);
      start_frame(OP_HEARTBEAT);    send_frame(32'h0);

      write_version(8'hFF);
      run_phase(12, 63, 12, 1'b0);
      write_version(8'h00);
      run_phase(63, 12, 12, 1'b1);
      write_version(8'($urandom_range(255)));
      run_phase(0, 0, 12, 1'b0);

      wait_drained();
      repeat (8) @(negedge clock);

      $display("covered %0d command bytes and %0d reply transfers: every opcode, unknown",
               bytes_sent, book.replies_seen);
      $display("opcodes, missing, extra and overlong arguments, four version settings");
      if (book.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", book.mismatches);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
